// File: hdl/kohonen_palette_trainer_assert.svh
// assertion macros for the kohonen palette trainer
// no dependencies; included by modules that carry concurrent checks
`ifndef KOHONEN_PALETTE_TRAINER_ASSERT_SVH
`define KOHONEN_PALETTE_TRAINER_ASSERT_SVH

// same-cycle implication under active-low async reset
`define KPT_ASSERT_HOLDS(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("kohonen_palette_trainer: check failed");

// next-cycle implication under active-low async reset
`define KPT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("kohonen_palette_trainer: check failed");

`endif

// File: hdl/khp_pkg.sv
// shared types, constants and helpers for the kohonen palette trainer
// no dependencies
package khp_pkg;

	localparam int NET_SIZE_DEF    = 256;
	localparam int MAX_RADIUS_DEF  = 32;
	localparam int PUSH_LIMIT      = 16;
	localparam int PUSH_RAISE      = 4;
	localparam int PUSH_LOWER      = 1;
	localparam int NEAR_LIMIT      = 128;
	localparam int ONE_RATE        = 1024;

	localparam logic OP_TRAIN = 1'b0;
	localparam logic OP_SCHED = 1'b1;

	// falloff divider sizing, covers radius up to 64
	localparam int DIVN_W = 31;
	localparam int DIVD_W = 13;
	localparam int DIVQ_W = 19;

	typedef struct packed {
		logic               operation;
		logic [7:0]         sample_alpha;
		logic [14:0]        lab_l;
		logic signed [15:0] lab_a;
		logic signed [15:0] lab_b;
		logic [10:0]        rate;
		logic [5:0]         radius;
	} cmd_t;

	typedef struct packed {
		logic [7:0] winner;
		logic       perfect;
	} rsp_t;

	typedef struct packed {
		logic signed [23:0] alpha;
		logic signed [23:0] l;
		logic signed [23:0] a;
		logic signed [23:0] b;
		logic [31:0]        freq;
		logic signed [31:0] bias;
		logic [4:0]         repel;
	} neuron_t;

	localparam int NRN_W = $bits(neuron_t);

	typedef struct packed {
		logic              start;
		logic [DIVN_W-1:0] num;
		logic [DIVD_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVQ_W-1:0] quot;
	} div_rsp_t;

	function automatic logic signed [23:0] sat24(input logic signed [47:0] v);
		logic signed [23:0] r;
		if (v > 48'sd8388607)
			r = 24'sh7fffff;
		else if (v < -48'sd8388608)
			r = 24'sh800000;
		else
			r = v[23:0];
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -34'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [23:0] comp_get(input neuron_t n, input logic [1:0] c);
		logic signed [23:0] r;
		case (c)
			2'd0: r = n.alpha;
			2'd1: r = n.l;
			2'd2: r = n.a;
			default: r = n.b;
		endcase
		return r;
	endfunction

	function automatic neuron_t comp_set(input neuron_t n, input logic [1:0] c,
	                                     input logic signed [23:0] v);
		neuron_t r;
		r = n;
		case (c)
			2'd0: r.alpha = v;
			2'd1: r.l = v;
			2'd2: r.a = v;
			default: r.b = v;
		endcase
		return r;
	endfunction

endpackage

// File: hdl/khp_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module khp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/khp_div.sv
// restoring divider, one quotient bit per cycle, for the falloff table
// depends on khp_pkg
module khp_div (
	input  logic              clk,
	input  logic              arst_n,
	input  khp_pkg::div_req_t req,
	output khp_pkg::div_rsp_t rsp
);
	import khp_pkg::*;

	localparam int CNT_W = $clog2(DIVN_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] den_q;
	logic [DIVN_W-1:0] quo_q;
	logic [DIVD_W:0]   sh;
	logic              ge;

	assign sh = {rem_q, quo_q[DIVN_W-1]};
	assign ge = sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVN_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? DIVD_W'(sh - {1'b0, den_q}) : sh[DIVD_W-1:0];
			quo_q <= {quo_q[DIVN_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q[DIVQ_W-1:0];

endmodule

// File: hdl/kohonen_palette_trainer.sv
// kohonen palette trainer top level: sequencer, shared multiplier, neuron and falloff rams
// depends on khp_pkg, khp_ram, khp_div and kohonen_palette_trainer_assert.svh

// After reset the block runs a clearing pass over the neuron and falloff rams
// with busy high, then takes one item per start while busy is low. A train item
// scans the active neurons one at a time (one ram port, read then compare),
// boosts the closest neuron, pulls the winner, then, if the radius is nonzero,
// either pulls up to 2*radius neighbours or, on a perfect match, runs a repel
// scan over the active neurons unless the winner's repel score is over its limit.
// A schedule item rebuilds the falloff table with a bit-serial divider, one
// division per entry below the radius and a zero for every other entry. Each item
// gives one result beat on done for one cycle; the receiver cannot stall it, so it
// must be taken as it appears.
`include "kohonen_palette_trainer_assert.svh"

module kohonen_palette_trainer #(
	parameter int NET_SIZE   = khp_pkg::NET_SIZE_DEF,
	parameter int MAX_RADIUS = khp_pkg::MAX_RADIUS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  khp_pkg::cmd_t  item,
	output logic           busy,
	output logic           done,
	output khp_pkg::rsp_t  result,
	input  logic           cfg_we,
	input  logic [8:0]     cfg_wdata
);
	import khp_pkg::*;

	localparam int IDX_W = $clog2(NET_SIZE);
	localparam int N_W   = $clog2(NET_SIZE + 1);
	localparam int FT_D  = MAX_RADIUS + 1;
	localparam int RAD_W = $clog2(FT_D);
	localparam int CLR_N = (NET_SIZE > FT_D) ? NET_SIZE : FT_D;
	localparam int CLR_W = $clog2(CLR_N);
	localparam int SUM_W = ((IDX_W > RAD_W) ? IDX_W : RAD_W) + 1;
	localparam logic [31:0] FREQ_INIT = 32'((2**30) / NET_SIZE);
	localparam logic signed [53:0] BIG_DIST = 54'sd2251799812636672;

	localparam logic [4:0] ST_CLR  = 5'd0;
	localparam logic [4:0] ST_IDLE = 5'd1;
	localparam logic [4:0] SC_R2   = 5'd2;
	localparam logic [4:0] SC_R2W  = 5'd3;
	localparam logic [4:0] SC_SQ   = 5'd4;
	localparam logic [4:0] SC_NUM  = 5'd5;
	localparam logic [4:0] SC_DIV  = 5'd6;
	localparam logic [4:0] SC_WT   = 5'd7;
	localparam logic [4:0] T_RD    = 5'd8;
	localparam logic [4:0] T_CMP   = 5'd9;
	localparam logic [4:0] T_CMP2  = 5'd10;
	localparam logic [4:0] T_BRD   = 5'd11;
	localparam logic [4:0] T_BWR   = 5'd12;
	localparam logic [4:0] T_AFT   = 5'd13;
	localparam logic [4:0] P_RD    = 5'd14;
	localparam logic [4:0] P_LD    = 5'd15;
	localparam logic [4:0] P_MUL   = 5'd16;
	localparam logic [4:0] P_RND   = 5'd17;
	localparam logic [4:0] P_WR    = 5'd18;
	localparam logic [4:0] R_RD    = 5'd19;
	localparam logic [4:0] R_CHK   = 5'd20;
	localparam logic [4:0] R_JRD   = 5'd21;
	localparam logic [4:0] R_JUP   = 5'd22;
	localparam logic [4:0] R_FRD   = 5'd23;
	localparam logic [4:0] R_FWR   = 5'd24;
	localparam logic [4:0] N_WRD   = 5'd25;
	localparam logic [4:0] N_WGT   = 5'd26;
	localparam logic [4:0] N_UP    = 5'd27;
	localparam logic [4:0] N_DN    = 5'd28;
	localparam logic [4:0] N_NX    = 5'd29;
	localparam logic [4:0] ST_DONE = 5'd30;

	logic [4:0]             state_q;
	logic [4:0]             ret_q;
	logic [CLR_W-1:0]       clr_q;
	logic [N_W-1:0]         n_q;
	logic [10:0]            rate_q;
	logic [RAD_W-1:0]       rad_q;
	logic [RAD_W-1:0]       sc_i_q;
	logic [RAD_W-1:0]       m_q;
	logic [12:0]            r2_q;
	logic [IDX_W-1:0]       i_q;
	logic [IDX_W-1:0]       bp_q;
	logic [IDX_W-1:0]       bbp_q;
	logic [IDX_W-1:0]       win_q;
	logic [IDX_W-1:0]       p_addr_q;
	logic                   p_kind_q;
	logic [1:0]             c_q;
	logic                   perf_q;
	logic                   near_q;
	logic [26:0]            dist_q;
	logic signed [31:0]     bias_q;
	logic signed [53:0]     bestd_q;
	logic signed [53:0]     bestb_q;
	logic [18:0]            w_q;
	logic [8:0]             step_q;
	neuron_t                smp_q;
	neuron_t                ref_q;
	neuron_t                rec_q;
	logic signed [45:0]     prod_q;
	logic                   done_q;
	rsp_t                   result_q;

	logic signed [25:0]     mul_a;
	logic signed [19:0]     mul_b;
	logic                   nrn_we;
	logic [IDX_W-1:0]       nrn_waddr;
	logic [IDX_W-1:0]       nrn_raddr;
	neuron_t                nrn_wdata;
	logic [NRN_W-1:0]       nrn_rdata;
	neuron_t                rd;
	logic                   ft_we;
	logic [RAD_W-1:0]       ft_waddr;
	logic [RAD_W-1:0]       ft_raddr;
	logic [18:0]            ft_wdata;
	logic [18:0]            ft_rdata;
	div_req_t               div_req;
	div_rsp_t               div_rsp;

	logic [IDX_W-1:0]       last_idx;
	neuron_t                clr_rec;
	neuron_t                smp_d;
	neuron_t                aged;
	neuron_t                boosted;
	neuron_t                pushed;
	logic                   cmp_near;
	logic [26:0]            cmp_dist;
	logic                   rep_near;
	logic signed [53:0]     d4;
	logic signed [53:0]     biased;
	logic signed [23:0]     p_cv;
	logic signed [24:0]     p_diff;
	logic signed [46:0]     p_rnd;
	logic signed [23:0]     p_nv;
	logic [SUM_W-1:0]       up_idx;
	logic [8:0]             cfg_sat;

	assign rd       = neuron_t'(nrn_rdata);
	assign last_idx = IDX_W'(n_q - 1'b1);
	assign up_idx   = SUM_W'(win_q) + SUM_W'(m_q);
	assign cfg_sat  = (cfg_wdata < 9'd3) ? 9'd3 :
	                  ((cfg_wdata > 9'(NET_SIZE)) ? 9'(NET_SIZE) : cfg_wdata);

	khp_ram #(.WIDTH(NRN_W), .DEPTH(NET_SIZE)) u_nrn_ram (
		.clk   (clk),
		.we    (nrn_we),
		.waddr (nrn_waddr),
		.wdata (nrn_wdata),
		.raddr (nrn_raddr),
		.rdata (nrn_rdata)
	);

	khp_ram #(.WIDTH(19), .DEPTH(FT_D)) u_ft_ram (
		.clk   (clk),
		.we    (ft_we),
		.waddr (ft_waddr),
		.wdata (ft_wdata),
		.raddr (ft_raddr),
		.rdata (ft_rdata)
	);

	khp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// reset contents of one neuron during the clearing pass
	always_comb begin
		clr_rec = '0;
		if (int'(clr_q) >= 3) begin
			clr_rec.freq = FREQ_INIT;
			if (int'(clr_q) < 16)
				clr_rec.alpha = 24'(clr_q) <<< 12;
			else
				clr_rec.alpha = 24'sd65280;
		end
	end

	// sample held for the whole item
	always_comb begin
		smp_d       = '0;
		smp_d.alpha = 24'({item.sample_alpha, 8'd0});
		smp_d.l     = 24'(item.lab_l);
		smp_d.a     = 24'(item.lab_a);
		smp_d.b     = 24'(item.lab_b);
	end

	// competition distance and ageing of the neuron just read
	always_comb begin
		logic signed [24:0] dif;
		logic [24:0]        ad;
		logic [31:0]        bf;
		cmp_near = 1'b1;
		cmp_dist = '0;
		for (int c = 0; c < 4; c++) begin
			dif = 25'(comp_get(rd, 2'(c))) - 25'(comp_get(smp_q, 2'(c)));
			ad  = (dif < 0) ? 25'(-dif) : 25'(dif);
			if (ad >= 25'(NEAR_LIMIT))
				cmp_near = 1'b0;
			cmp_dist = cmp_dist + 27'(ad);
		end
		bf         = rd.freq >> 10;
		aged       = rd;
		aged.freq  = rd.freq - bf;
		aged.bias  = sat32(34'(rd.bias) + 34'(bf));
	end

	// closest-neuron reward
	always_comb begin
		logic [32:0] f;
		f            = 33'(rd.freq) + 33'(32'd1 << 20);
		boosted      = rd;
		boosted.freq = f[32] ? 32'hffffffff : f[31:0];
		boosted.bias = sat32(34'(rd.bias) - 34'sd1048576);
	end

	// repel push of the neuron just read, relative to the winner
	always_comb begin
		logic signed [24:0] dif;
		logic [24:0]        ad;
		logic signed [23:0] v;
		rep_near = 1'b1;
		pushed   = rd;
		for (int c = 0; c < 4; c++) begin
			v   = comp_get(rd, 2'(c));
			dif = 25'(v) - 25'(comp_get(ref_q, 2'(c)));
			ad  = (dif < 0) ? 25'(-dif) : 25'(dif);
			if (ad >= 25'(NEAR_LIMIT))
				rep_near = 1'b0;
			if (dif >= 0)
				pushed = comp_set(pushed, 2'(c), sat24(48'(v) + 48'(step_q)));
			else
				pushed = comp_set(pushed, 2'(c), sat24(48'(v) - 48'(step_q)));
		end
	end

	assign d4     = 54'({dist_q, 12'd0});
	assign biased = bestb_q + 54'(bias_q);

	// pull datapath: one component per multiply
	assign p_cv   = comp_get(rec_q, c_q);
	assign p_diff = 25'(p_cv) - 25'(comp_get(smp_q, c_q));
	assign p_rnd  = p_kind_q ? ((47'(prod_q) + 47'sd131072) >>> 18)
	                         : ((47'(prod_q) + 47'sd512) >>> 10);
	assign p_nv   = sat24(48'(p_cv) - 48'(p_rnd));

	always_comb begin
		nrn_we    = 1'b0;
		nrn_waddr = i_q;
		nrn_wdata = rec_q;
		nrn_raddr = i_q;
		ft_we     = 1'b0;
		ft_waddr  = sc_i_q;
		ft_wdata  = '0;
		ft_raddr  = m_q;
		mul_a     = '0;
		mul_b     = '0;
		div_req   = '0;
		case (state_q)
			ST_CLR: begin
				nrn_we    = int'(clr_q) < NET_SIZE;
				nrn_waddr = clr_q[IDX_W-1:0];
				nrn_wdata = clr_rec;
				ft_we     = int'(clr_q) < FT_D;
				ft_waddr  = clr_q[RAD_W-1:0];
			end
			SC_R2: begin
				mul_a = 26'(rad_q);
				mul_b = 20'(rad_q);
			end
			SC_SQ: begin
				if (sc_i_q >= rad_q)
					ft_we = 1'b1;
				mul_a = 26'(sc_i_q);
				mul_b = 20'(sc_i_q);
			end
			SC_NUM: begin
				mul_a = 26'(rate_q);
				mul_b = 20'(r2_q) - 20'(prod_q[12:0]);
			end
			SC_DIV: begin
				div_req.start = 1'b1;
				div_req.num   = {prod_q[22:0], 8'd0};
				div_req.den   = r2_q;
			end
			SC_WT: begin
				ft_we    = div_rsp.done;
				ft_wdata = div_rsp.quot;
			end
			T_CMP: begin
				nrn_we    = 1'b1;
				nrn_wdata = aged;
			end
			T_BRD: nrn_raddr = bp_q;
			T_BWR: begin
				nrn_we    = 1'b1;
				nrn_waddr = bp_q;
				nrn_wdata = boosted;
			end
			P_RD: nrn_raddr = p_addr_q;
			P_MUL: begin
				mul_a = 26'(p_diff);
				mul_b = p_kind_q ? 20'(w_q) : 20'(rate_q);
			end
			P_WR: begin
				nrn_we    = 1'b1;
				nrn_waddr = p_addr_q;
			end
			R_RD: begin
				nrn_raddr = win_q;
				ft_raddr  = '0;
			end
			R_CHK: begin
				nrn_waddr       = win_q;
				nrn_wdata       = rd;
				nrn_wdata.repel = rd.repel - 5'(PUSH_LOWER);
				nrn_we          = rd.repel > 5'(PUSH_LIMIT);
			end
			R_JUP: begin
				nrn_we    = rep_near;
				nrn_wdata = pushed;
			end
			R_FRD: nrn_raddr = win_q;
			R_FWR: begin
				nrn_we          = 1'b1;
				nrn_waddr       = win_q;
				nrn_wdata       = rd;
				nrn_wdata.repel = rd.repel + 5'(PUSH_RAISE);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= 46'(mul_a) * 46'(mul_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			n_q      <= N_W'(NET_SIZE);
			rate_q   <= 11'(ONE_RATE);
			rad_q    <= '0;
			done_q   <= 1'b0;
			perf_q   <= 1'b0;
			win_q    <= '0;
			ret_q    <= ST_IDLE;
		end else begin
			done_q <= 1'b0;
			if (cfg_we)
				n_q <= N_W'(cfg_sat);
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_W'(CLR_N - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						perf_q <= 1'b0;
						win_q  <= '0;
						smp_q  <= smp_d;
						if (item.operation == OP_SCHED) begin
							rate_q <= (item.rate > 11'(ONE_RATE)) ? 11'(ONE_RATE) : item.rate;
							if (item.radius <= 6'd1)
								rad_q <= '0;
							else if (7'(item.radius) > 7'(MAX_RADIUS))
								rad_q <= RAD_W'(MAX_RADIUS);
							else
								rad_q <= RAD_W'(item.radius);
							sc_i_q  <= '0;
							state_q <= SC_R2;
						end else begin
							i_q     <= '0;
							bp_q    <= '0;
							bbp_q   <= '0;
							bestd_q <= BIG_DIST;
							bestb_q <= BIG_DIST;
							state_q <= T_RD;
						end
					end
				end
				SC_R2: state_q <= SC_R2W;
				SC_R2W: begin
					r2_q    <= prod_q[12:0];
					state_q <= SC_SQ;
				end
				SC_SQ: begin
					if (sc_i_q >= rad_q) begin
						if (sc_i_q == RAD_W'(MAX_RADIUS))
							state_q <= ST_DONE;
						else
							sc_i_q <= sc_i_q + 1'b1;
					end else begin
						state_q <= SC_NUM;
					end
				end
				SC_NUM: state_q <= SC_DIV;
				SC_DIV: state_q <= SC_WT;
				SC_WT: begin
					if (div_rsp.done) begin
						if (sc_i_q == RAD_W'(MAX_RADIUS)) begin
							state_q <= ST_DONE;
						end else begin
							sc_i_q  <= sc_i_q + 1'b1;
							state_q <= SC_SQ;
						end
					end
				end
				T_RD: state_q <= T_CMP;
				T_CMP: begin
					dist_q  <= cmp_near ? '0 : cmp_dist;
					near_q  <= cmp_near;
					bias_q  <= rd.bias;
					state_q <= T_CMP2;
				end
				T_CMP2: begin
					// search stops at the first perfect match, ageing does not
					if (!perf_q) begin
						if (d4 < bestd_q) begin
							bestd_q <= d4;
							bp_q    <= i_q;
						end
						if (d4 < biased) begin
							bestb_q <= d4 - 54'(bias_q);
							bbp_q   <= i_q;
						end
						if (near_q)
							perf_q <= 1'b1;
					end
					if (i_q == last_idx) begin
						state_q <= T_BRD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= T_RD;
					end
				end
				T_BRD: state_q <= T_BWR;
				T_BWR: begin
					win_q    <= perf_q ? bp_q : bbp_q;
					p_addr_q <= perf_q ? bp_q : bbp_q;
					p_kind_q <= 1'b0;
					ret_q    <= T_AFT;
					state_q  <= P_RD;
				end
				T_AFT: begin
					if (rad_q == '0)
						state_q <= ST_DONE;
					else if (perf_q)
						state_q <= R_RD;
					else begin
						m_q     <= RAD_W'(1);
						state_q <= N_WRD;
					end
				end
				P_RD: state_q <= P_LD;
				P_LD: begin
					rec_q   <= rd;
					c_q     <= '0;
					state_q <= P_MUL;
				end
				P_MUL: state_q <= P_RND;
				P_RND: begin
					rec_q <= comp_set(rec_q, c_q, p_nv);
					c_q   <= c_q + 1'b1;
					state_q <= (c_q == 2'd3) ? P_WR : P_MUL;
				end
				P_WR: state_q <= ret_q;
				R_RD: state_q <= R_CHK;
				R_CHK: begin
					if (rd.repel > 5'(PUSH_LIMIT)) begin
						state_q <= ST_DONE;
					end else begin
						ref_q   <= rd;
						step_q  <= 9'((20'(ft_rdata) + 20'd1024) >> 11);
						i_q     <= '0;
						state_q <= R_JRD;
					end
				end
				R_JRD: state_q <= R_JUP;
				R_JUP: begin
					if (i_q == last_idx) begin
						state_q <= R_FRD;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= R_JRD;
					end
				end
				R_FRD: state_q <= R_FWR;
				R_FWR: state_q <= ST_DONE;
				N_WRD: state_q <= N_WGT;
				N_WGT: begin
					w_q     <= ft_rdata;
					state_q <= N_UP;
				end
				N_UP: begin
					p_kind_q <= 1'b1;
					if (up_idx < SUM_W'(n_q)) begin
						p_addr_q <= up_idx[IDX_W-1:0];
						ret_q    <= N_DN;
						state_q  <= P_RD;
					end else begin
						state_q <= N_DN;
					end
				end
				N_DN: begin
					if (SUM_W'(win_q) >= SUM_W'(m_q)) begin
						p_addr_q <= IDX_W'(SUM_W'(win_q) - SUM_W'(m_q));
						ret_q    <= N_NX;
						state_q  <= P_RD;
					end else begin
						state_q <= N_NX;
					end
				end
				N_NX: begin
					if (m_q == rad_q) begin
						state_q <= ST_DONE;
					end else begin
						m_q     <= m_q + 1'b1;
						state_q <= N_WRD;
					end
				end
				ST_DONE: begin
					done_q   <= 1'b1;
					result_q <= '{winner: 8'(win_q), perfect: perf_q};
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	`KPT_ASSERT_NEXT(a_single_beat, clk, arst_n, done, !done)
	`KPT_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`KPT_ASSERT_HOLDS(a_n_range, clk, arst_n, 1'b1, n_q >= N_W'(3) && n_q <= N_W'(NET_SIZE))
	`KPT_ASSERT_HOLDS(a_win_range, clk, arst_n, done, 9'(result.winner) < 9'(n_q))

endmodule

// File: verif/tb_kohonen_palette_trainer.sv
// self-checking testbench for kohonen_palette_trainer: queue-fed driver, clocked monitor
// and a local model of the neuron table that predicts winner and perfect for every beat
// depends on khp_pkg and the kohonen_palette_trainer rtl
module tb_kohonen_palette_trainer;
	import khp_pkg::*;

	localparam int  NSZ       = 256;
	localparam int  MRAD      = 32;
	localparam longint FAR    = 64'd2147483647 * 64'd1048576;
	localparam int  CYC_LIMIT = 30000000;

	typedef bit bool_t;

	logic          clk;
	logic          arst_n;
	logic          start;
	cmd_t          item;
	logic          busy;
	logic          done;
	rsp_t          result;
	logic          cfg_we;
	logic [8:0]    cfg_wdata;

	kohonen_palette_trainer dut (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .busy(busy),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// model state: channel 0 alpha, 1 l, 2 a, 3 b
	int          chn[4][NSZ];
	int unsigned freq[NSZ];
	int          bias[NSZ];
	int          rscore[NSZ];
	longint      fall[MRAD+1];
	longint      cur_rate;
	int          cur_rad;
	int          n_act;

	cmd_t  pend_q[$];
	rsp_t  rsp_q[$];
	cmd_t  hist[$];
	int    idle_pct;
	int    fails;
	int    n_trains, n_scheds, n_perfect;
	longint cycles;

	function automatic longint clip24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function automatic int clip32(longint v);
		if (v > 64'sd2147483647) return 32'h7fffffff;
		if (v < -64'sd2147483648) return 32'h80000000;
		return int'(v);
	endfunction

	function automatic longint round_shift(longint v, int k);
		longint x;
		x = v + (64'sd1 <<< (k - 1));
		return x >>> k;
	endfunction

	function automatic void net_reset();
		for (int i = 0; i < NSZ; i++) begin
			chn[0][i] = (i < 3) ? 0 : (i < 16 ? i * 16 * 256 : 255 * 256);
			for (int c = 1; c < 4; c++)
				chn[c][i] = 0;
			freq[i] = (i < 3) ? 0 : (32'd1 << 30) / NSZ;
			bias[i] = 0;
			rscore[i] = 0;
		end
		for (int i = 0; i <= MRAD; i++)
			fall[i] = 0;
		cur_rate = ONE_RATE;
		cur_rad = 0;
		n_act = NSZ;
	endfunction

	function automatic void set_active(logic [8:0] v);
		n_act = (v < 3) ? 3 : (v > NSZ ? NSZ : int'(v));
	endfunction

	function automatic void move_neuron(int idx, longint s[4], longint w, int k);
		longint v;
		for (int c = 0; c < 4; c++) begin
			v = chn[c][idx];
			v = v - round_shift((v - s[c]) * w, k);
			chn[c][idx] = int'(clip24(v));
		end
	endfunction

	function automatic void push_apart(int win);
		longint ref_v[4];
		longint step, d;
		bool_t near;
		if (rscore[win] > PUSH_LIMIT) begin
			rscore[win] -= PUSH_LOWER;
			return;
		end
		for (int c = 0; c < 4; c++)
			ref_v[c] = chn[c][win];
		step = (fall[0] + 1024) >> 11;
		for (int j = 0; j < n_act; j++) begin
			near = 1;
			for (int c = 0; c < 4; c++) begin
				d = chn[c][j] - ref_v[c];
				if (d >= NEAR_LIMIT || -d >= NEAR_LIMIT)
					near = 0;
			end
			if (near) begin
				for (int c = 0; c < 4; c++) begin
					d = chn[c][j] - ref_v[c];
					chn[c][j] = int'(clip24(chn[c][j] + (d >= 0 ? step : -step)));
				end
			end
		end
		rscore[win] += PUSH_RAISE;
	endfunction

	// expected response for one accepted command, updates the model
	function automatic rsp_t train_step(cmd_t cmd);
		rsp_t   r;
		longint s[4];
		longint bestd, bestb, dsum, d, rr, r2, f;
		int     bp, bbp, win, hi, rad;
		bit     perf, near;
		int unsigned bf;
		r = '0;
		if (cmd.operation == OP_SCHED) begin
			rr = cmd.rate;
			rad = cmd.radius;
			if (rr > ONE_RATE) rr = ONE_RATE;
			if (rad <= 1) rad = 0;
			if (rad > MRAD) rad = MRAD;
			cur_rate = rr;
			cur_rad = rad;
			r2 = rad * rad;
			for (int i = 0; i <= MRAD; i++)
				fall[i] = (i < rad) ? (rr * (r2 - i * i) * 256) / r2 : 0;
			n_scheds++;
			return r;
		end
		s[0] = longint'(cmd.sample_alpha) * 256;
		s[1] = longint'(cmd.lab_l);
		s[2] = longint'(cmd.lab_a);
		s[3] = longint'(cmd.lab_b);
		bestd = FAR;
		bestb = FAR;
		bp = 0;
		bbp = 0;
		perf = 0;
		for (int i = 0; i < n_act; i++) begin
			if (!perf) begin
				dsum = 0;
				near = 1;
				for (int c = 0; c < 4; c++) begin
					d = chn[c][i] - s[c];
					if (d < 0) d = -d;
					if (d >= NEAR_LIMIT) near = 0;
					dsum += d;
				end
				if (near) begin
					perf = 1;
					dsum = 0;
				end
				dsum *= 4096;
				if (dsum < bestd) begin
					bestd = dsum;
					bp = i;
				end
				if (dsum < bestb + bias[i]) begin
					bestb = dsum - bias[i];
					bbp = i;
				end
			end
			bf = freq[i] >> 10;
			freq[i] -= bf;
			bias[i] = clip32(longint'(bias[i]) + bf);
		end
		f = longint'(freq[bp]) + (64'd1 << 20);
		freq[bp] = (f > 64'hffffffff) ? 32'hffffffff : f[31:0];
		bias[bp] = clip32(longint'(bias[bp]) - (64'd1 << 20));
		win = perf ? bp : bbp;
		move_neuron(win, s, cur_rate, 10);
		if (cur_rad != 0) begin
			if (perf) begin
				push_apart(win);
			end else begin
				hi = (win + cur_rad > n_act - 1) ? n_act - 1 : win + cur_rad;
				for (int m = 1; m <= cur_rad; m++) begin
					if (win + m <= hi)
						move_neuron(win + m, s, fall[m], 18);
					if (win >= m)
						move_neuron(win - m, s, fall[m], 18);
				end
			end
		end
		n_trains++;
		if (perf) n_perfect++;
		r.winner = win[7:0];
		r.perfect = perf;
		return r;
	endfunction

	function automatic cmd_t mk_sched(int rate, int rad);
		cmd_t c;
		c = '0;
		c.operation = OP_SCHED;
		c.rate = rate[10:0];
		c.radius = rad[5:0];
		c.sample_alpha = 8'($urandom);
		c.lab_l = 15'($urandom);
		c.lab_a = 16'($urandom);
		c.lab_b = 16'($urandom);
		return c;
	endfunction

	function automatic cmd_t mk_train(int al, int l, int a, int b);
		cmd_t c;
		c = '0;
		c.operation = OP_TRAIN;
		c.sample_alpha = al[7:0];
		c.lab_l = l[14:0];
		c.lab_a = a[15:0];
		c.lab_b = b[15:0];
		c.rate = 11'($urandom);
		c.radius = 6'($urandom);
		return c;
	endfunction

	// mostly samples near recent ones so perfect matches and repel passes happen
	function automatic cmd_t rand_cmd();
		cmd_t c;
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			if ($urandom_range(3) == 0)
				c = mk_sched($urandom_range(2047), $urandom_range(63));
			else
				c = mk_sched($urandom_range(1024), $urandom_range(12));
		end else if (pick < 60 && hist.size() > 0) begin
			c = hist[$urandom_range(hist.size() - 1)];
			if ($urandom_range(2) == 0) begin
				c.lab_l = 15'(int'(c.lab_l) + int'($urandom_range(200)) - 100);
				c.lab_a = 16'(int'(c.lab_a) + int'($urandom_range(200)) - 100);
				c.lab_b = 16'(int'(c.lab_b) + int'($urandom_range(200)) - 100);
			end
		end else if (pick < 80) begin
			c = mk_train($urandom_range(255), $urandom_range(25600),
			             $urandom_range(8000) - 4000, $urandom_range(8000) - 4000);
		end else begin
			c = mk_train($urandom, $urandom, $urandom, $urandom);
		end
		if (c.operation == OP_TRAIN) begin
			hist.push_back(c);
			if (hist.size() > 12)
				void'(hist.pop_front());
		end
		return c;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			item <= '0;
		end else if (!start || !busy) begin
			if (pend_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				item <= pend_q.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// response monitor and model update
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYC_LIMIT) begin
			$display("timeout at %0t", $time);
			$display("FAIL");
			$finish;
		end
		if (arst_n) begin
			if (done) begin
				if (rsp_q.size() == 0) begin
					$display("%0t: unexpected beat winner=%0d perfect=%0d",
					         $time, result.winner, result.perfect);
					fails++;
				end else begin
					rsp_t e;
					e = rsp_q.pop_front();
					if (e.winner !== result.winner) begin
						$display("%0t: winner exp=%0d got=%0d", $time, e.winner, result.winner);
						fails++;
					end
					if (e.perfect !== result.perfect) begin
						$display("%0t: perfect exp=%0d got=%0d", $time, e.perfect,
						         result.perfect);
						fails++;
					end
				end
			end
			if (cfg_we)
				set_active(cfg_wdata);
			if (start && !busy)
				rsp_q.push_back(train_step(item));
		end
	end

	task automatic drain();
		while (pend_q.size() > 0 || rsp_q.size() > 0 || start || busy)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_active(int v);
		cfg_we <= 1'b1;
		cfg_wdata <= v[8:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	int phase_pct[4] = '{0, 74, 0, 13};
	int phase_act[4] = '{3, 511, 40, 0};

	initial begin
		fails = 0;
		n_trains = 0;
		n_scheds = 0;
		n_perfect = 0;
		cycles = 0;
		idle_pct = 0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		arst_n = 1'b0;
		net_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset net, extremes of fields, schedules at the edges
		pend_q.push_back(mk_train(0, 0, 0, 0));
		pend_q.push_back(mk_train(255, 32767, 32767, 32767));
		pend_q.push_back(mk_train(255, 0, -32768, -32768));
		pend_q.push_back(mk_sched(2047, 63));
		pend_q.push_back(mk_train(128, 12800, 1000, -1000));
		pend_q.push_back(mk_train(128, 12800, 1000, -1000));
		pend_q.push_back(mk_sched(1024, 1));
		pend_q.push_back(mk_train(10, 25600, -5, 5));
		pend_q.push_back(mk_sched(0, 32));
		pend_q.push_back(mk_train(200, 300, 300, 300));
		pend_q.push_back(mk_sched(700, 4));
		// repeated perfect matches drive the repel score past its threshold
		for (int i = 0; i < 7; i++)
			pend_q.push_back(mk_train(0, 0, 0, 0));
		pend_q.push_back(mk_sched(1024, 2));
		pend_q.push_back(mk_train(255, 1, 1, 1));
		pend_q.push_back(mk_train(255, 1, 1, 1));
		pend_q.push_back(mk_train(17, 32767, -32768, 32767));
		drain();
		write_active(256);

		for (int p = 0; p < 4; p++) begin
			idle_pct = phase_pct[p];
			for (int i = 0; i < 240; i++)
				pend_q.push_back(rand_cmd());
			drain();
			write_active(phase_act[p]);
		end

		$display("ran %0d train and %0d schedule commands, %0d perfect matches,",
		         n_trains, n_scheds, n_perfect);
		$display("over several active sizes and sender gap rates");
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// File: kohonen_palette_trainer.f
+incdir+hdl
hdl/khp_pkg.sv
hdl/khp_ram.sv
hdl/khp_div.sv
hdl/kohonen_palette_trainer.sv
verif/tb_kohonen_palette_trainer.sv
